/* hw/rtl/pic_pkg.sv */
`timescale 1ns / 1ps

package pic_pkg;

  // default sizes
  localparam int unsigned MAX_ATOMS_DEF  = 256;
  localparam int unsigned COORD_BITS_DEF = 32;

  // field widths
  localparam int unsigned AN_W     = 8;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned FLAG_W   = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned CLASH_W  = 8;
  localparam int unsigned HELD_W   = 9;
  localparam int unsigned TOL_W    = 40;
  localparam int unsigned DIST_W   = 64;

  localparam logic [TOL_W-1:0] TOL_RESET = 40'd281;

  // input tdata layout
  localparam int unsigned IN_AN_LSB   = 0;
  localparam int unsigned IN_X_LSB    = IN_AN_LSB + AN_W;
  localparam int unsigned IN_Y_LSB    = IN_X_LSB + POS_W;
  localparam int unsigned IN_Z_LSB    = IN_Y_LSB + POS_W;
  localparam int unsigned IN_FLAG_LSB = IN_Z_LSB + POS_W;
  localparam int unsigned IN_USED_W   = IN_FLAG_LSB + FLAG_W;
  localparam int unsigned IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout
  localparam int unsigned OUT_STAT_LSB  = 0;
  localparam int unsigned OUT_ID_LSB    = OUT_STAT_LSB + STAT_W;
  localparam int unsigned OUT_CLASH_LSB = OUT_ID_LSB + ID_W;
  localparam int unsigned OUT_HELD_LSB  = OUT_CLASH_LSB + CLASH_W;
  localparam int unsigned OUT_USED_W    = OUT_HELD_LSB + HELD_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [STAT_W-1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_COLOC    = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic    latch_in;
    logic    issue;
    logic    flush;
    logic    load_result;
    status_e res;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_end;
    logic pipe_busy;
    logic hit;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/pic_ctrl.sv */
`timescale 1ns / 1ps

module pic_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  pic_pkg::dp_stat_t  stat_i,
  output pic_pkg::ctrl_cmd_t cmd_o
);

  pic_pkg::ctrl_state_e state_q, state_d;
  pic_pkg::status_e     res_q, res_d;
  logic                 accept;

  assign accept = s_axis_tvalid && (state_q == pic_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pic_pkg::S_IDLE;
      res_q   <= pic_pkg::STATUS_ACCEPTED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      pic_pkg::S_IDLE: begin
        if (accept) begin
          if (stat_i.full) begin
            res_d   = pic_pkg::STATUS_FULL;
            state_d = pic_pkg::S_FINISH;
          end else begin
            res_d   = pic_pkg::STATUS_ACCEPTED;
            state_d = pic_pkg::S_SCAN;
          end
        end
      end
      pic_pkg::S_SCAN: begin
        if (stat_i.hit) begin
          res_d   = pic_pkg::STATUS_COLOC;
          state_d = pic_pkg::S_FINISH;
        end else if (stat_i.scan_end && !stat_i.pipe_busy) begin
          state_d = pic_pkg::S_FINISH;
        end
      end
      pic_pkg::S_FINISH: begin
        if (stat_i.out_free) begin
          state_d = pic_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pic_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.res     = res_q;
    s_axis_tready = 1'b0;
    case (state_q)
      pic_pkg::S_IDLE: begin
        s_axis_tready  = 1'b1;
        cmd_o.latch_in = accept;
      end
      pic_pkg::S_SCAN: begin
        cmd_o.issue = !stat_i.scan_end && !stat_i.hit;
        // first clash found, drop the reads still in flight
        cmd_o.flush = stat_i.hit;
      end
      pic_pkg::S_FINISH: begin
        cmd_o.load_result = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/pic_dp.sv */
`timescale 1ns / 1ps

module pic_dp #(
  parameter int unsigned MAX_ATOMS  = pic_pkg::MAX_ATOMS_DEF,
  parameter int unsigned COORD_BITS = pic_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pic_pkg::ctrl_cmd_t              cmd_i,
  output pic_pkg::dp_stat_t               stat_o,
  input  logic                            cfg_we_i,
  input  logic [pic_pkg::TOL_W-1:0]       cfg_wdata_i,
  input  logic [pic_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [pic_pkg::OUT_TDATA_W-1:0] out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ATOMS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_ATOMS);
  localparam int unsigned MAG_W = COORD_BITS + 1;
  localparam int unsigned REC_W = 3 * COORD_BITS + pic_pkg::AN_W + pic_pkg::FLAG_W;
  localparam int unsigned NSTG  = 5;

  localparam logic [pic_pkg::DIST_W-1:0] DIST_MAX = '1;

  // stored atoms: x, y, z, element, flags from the lowest bit up
  logic [REC_W-1:0] mem [MAX_ATOMS];
  logic [REC_W-1:0] rd_q;

  logic [COORD_BITS-1:0]      px_q, py_q, pz_q;
  logic [pic_pkg::AN_W-1:0]   an_q;
  logic [pic_pkg::FLAG_W-1:0] fl_q;

  logic [CNT_W-1:0]          count_q, rd_cnt_q;
  logic [pic_pkg::ID_W-1:0]  serial_q;
  logic [pic_pkg::TOL_W-1:0] tol_q;
  logic [NSTG-1:0]           valid_q;
  logic [IDX_W-1:0]          idx_q [NSTG];
  logic [IDX_W-1:0]          clash_q;

  logic [MAG_W-1:0]              mag_q [3];
  logic [pic_pkg::DIST_W-1:0]    sq_q [3];
  logic [pic_pkg::DIST_W-1:0]    sum1_q, sqz_q, sum2_q;

  logic                           out_valid_q;
  pic_pkg::status_e               ostat_q;
  logic [pic_pkg::ID_W-1:0]       oid_q;
  logic [pic_pkg::CLASH_W-1:0]    oclash_q;
  logic [pic_pkg::HELD_W-1:0]     oheld_q;

  logic commit;
  logic hit;

  function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                input logic [COORD_BITS-1:0] b);
    logic signed [MAG_W-1:0] d;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  function automatic logic [pic_pkg::DIST_W-1:0] sat_sq(input logic [MAG_W-1:0] mag);
    logic [32:0] m;
    m = 33'(mag);
    return m[32] ? DIST_MAX : (64'(m[31:0]) * 64'(m[31:0]));
  endfunction

  function automatic logic [pic_pkg::DIST_W-1:0] sat_add(
    input logic [pic_pkg::DIST_W-1:0] a,
    input logic [pic_pkg::DIST_W-1:0] b
  );
    logic [pic_pkg::DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[pic_pkg::DIST_W] ? DIST_MAX : s[pic_pkg::DIST_W-1:0];
  endfunction

  assign commit = cmd_i.load_result && (cmd_i.res == pic_pkg::STATUS_ACCEPTED);
  assign hit    = valid_q[NSTG-1] && (sum2_q < pic_pkg::DIST_W'(tol_q));

  assign stat_o.full      = (count_q == CNT_W'(MAX_ATOMS));
  assign stat_o.scan_end  = (rd_cnt_q == count_q);
  assign stat_o.pipe_busy = |valid_q;
  assign stat_o.hit       = hit;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      serial_q    <= '0;
      tol_q       <= pic_pkg::TOL_RESET;
      rd_cnt_q    <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (cmd_i.latch_in) begin
        rd_cnt_q <= '0;
      end else if (cmd_i.issue) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      if (cmd_i.flush) begin
        valid_q <= '0;
      end else begin
        valid_q <= {valid_q[NSTG-2:0], cmd_i.issue};
      end
      if (commit) begin
        count_q  <= count_q + 1'b1;
        serial_q <= serial_q + 1'b1;
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // atom store
  always_ff @(posedge clk_i) begin
    if (commit) begin
      mem[count_q[IDX_W-1:0]] <= {fl_q, an_q, pz_q, py_q, px_q};
    end
    if (cmd_i.issue) begin
      rd_q <= mem[rd_cnt_q[IDX_W-1:0]];
    end
  end

  // distance pipeline: read, |diff|, square, x+y, +z
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      px_q <= in_data_i[pic_pkg::IN_X_LSB +: COORD_BITS];
      py_q <= in_data_i[pic_pkg::IN_Y_LSB +: COORD_BITS];
      pz_q <= in_data_i[pic_pkg::IN_Z_LSB +: COORD_BITS];
      an_q <= in_data_i[pic_pkg::IN_AN_LSB +: pic_pkg::AN_W];
      fl_q <= in_data_i[pic_pkg::IN_FLAG_LSB +: pic_pkg::FLAG_W];
    end
    idx_q[0] <= rd_cnt_q[IDX_W-1:0];
    for (int k = 1; k < NSTG; k++) begin
      idx_q[k] <= idx_q[k-1];
    end
    mag_q[0] <= abs_diff(px_q, rd_q[0 +: COORD_BITS]);
    mag_q[1] <= abs_diff(py_q, rd_q[COORD_BITS +: COORD_BITS]);
    mag_q[2] <= abs_diff(pz_q, rd_q[2*COORD_BITS +: COORD_BITS]);
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= sat_sq(mag_q[k]);
    end
    sum1_q <= sat_add(sq_q[0], sq_q[1]);
    sqz_q  <= sq_q[2];
    sum2_q <= sat_add(sum1_q, sqz_q);
    if (hit) begin
      clash_q <= idx_q[NSTG-1];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      ostat_q <= cmd_i.res;
      case (cmd_i.res)
        pic_pkg::STATUS_ACCEPTED: begin
          oid_q    <= serial_q;
          oclash_q <= '0;
          oheld_q  <= pic_pkg::HELD_W'(count_q + 1'b1);
        end
        pic_pkg::STATUS_COLOC: begin
          oid_q    <= '0;
          oclash_q <= pic_pkg::CLASH_W'(clash_q);
          oheld_q  <= pic_pkg::HELD_W'(count_q);
        end
        default: begin
          oid_q    <= '0;
          oclash_q <= '0;
          oheld_q  <= pic_pkg::HELD_W'(count_q);
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = pic_pkg::OUT_TDATA_W'({oheld_q, oclash_q, oid_q, ostat_q});

endmodule

/* hw/rtl/point_insert_with_colocation_check.sv */
`timescale 1ns / 1ps
// Atom insertion with a colocation check.
// Slave stream s_axis carries one atom per transfer: element number, three
// signed coordinates (2^-24 angstrom per unit) and flag bits. Master stream
// m_axis returns one result per atom: status, assigned id, clash slot and the
// number of atoms held afterwards. cfg_we_i/cfg_wdata_i write the squared
// tolerance; write it only while no atom is in progress.
// A clash at slot k ends the scan early; a full store skips the scan and
// gives its result directly. Otherwise the scan runs over every stored atom
// in the atom memory, one read per cycle, then the five-stage distance
// pipeline (read, difference, square, two saturating adds).
// One atom is processed at a time; s_axis_tready is high only between atoms,
// so a new atom is taken only once the previous result has been loaded into
// the output register.
// The result sits in an output register, so the next atom can be taken while
// it waits; if the receiver stalls, the following result holds the block.
// Reset empties the store, clears the id counter and loads the default
// tolerance; no clearing pass is needed.

module point_insert_with_colocation_check #(
  parameter int unsigned MAX_ATOMS  = pic_pkg::MAX_ATOMS_DEF,
  parameter int unsigned COORD_BITS = pic_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pic_pkg::TOL_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // atomic_number, pos_x, pos_y, pos_z, atom_flags
  input  logic [pic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status, assigned_id, clash_index, atoms_held, zero pad
  output logic [pic_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  pic_pkg::ctrl_cmd_t cmd;
  pic_pkg::dp_stat_t  stat;

  pic_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  pic_dp #(
    .MAX_ATOMS  (MAX_ATOMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* hw/rtl/pic_checker.sv */
`timescale 1ns / 1ps

module pic_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pic_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [pic_pkg::STAT_W-1:0]  stat;
  logic [pic_pkg::ID_W-1:0]    id;
  logic [pic_pkg::CLASH_W-1:0] clash;

  assign stat  = m_axis_tdata[pic_pkg::OUT_STAT_LSB +: pic_pkg::STAT_W];
  assign id    = m_axis_tdata[pic_pkg::OUT_ID_LSB +: pic_pkg::ID_W];
  assign clash = m_axis_tdata[pic_pkg::OUT_CLASH_LSB +: pic_pkg::CLASH_W];

  // one atom at a time: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an atom is in progress");

  a_reject_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (stat != pic_pkg::STATUS_ACCEPTED) |-> (id == '0))
    else $error("rejected atom carries an id");

  a_clash_only_coloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (stat != pic_pkg::STATUS_COLOC) |-> (clash == '0))
    else $error("clash index set without a colocation");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind point_insert_with_colocation_check pic_checker u_pic_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import pic_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_ATOMS_DEF;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned RUN_LIMIT   = 4_000_000;
  localparam logic [TOL_W-1:0] TOL_MAX = '1;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    id;
    logic [CLASH_W-1:0] clash;
    logic [HELD_W-1:0]  held;
  } verdict_t;

  typedef struct packed {
    logic [IN_TDATA_W-1:0] data;
    logic                  typed;
    verdict_t              want;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [TOL_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // shadow of the atom store and the tolerance register
  logic signed [POS_W-1:0] pos_mem [STORE_DEPTH][3];
  int unsigned             n_held;
  logic [ID_W-1:0]         serial;
  logic [TOL_W-1:0]        tol_sq;

  verdict_t pending_verdicts [$];
  dir_row_t dir_rows [$];

  int unsigned send_pct;
  int unsigned stall_pct;
  bit          hold_req;
  int unsigned cycle_count;
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_accepted;
  int unsigned n_coloc;
  int unsigned n_full;
  int unsigned n_tol_writes;

  point_insert_with_colocation_check i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_verdicts.size());
    $display("** point_insert_with_colocation_check: FAILED **");
    $finish;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_atom(input logic [AN_W-1:0] an,
                                                      input logic [POS_W-1:0] x,
                                                      input logic [POS_W-1:0] y,
                                                      input logic [POS_W-1:0] z,
                                                      input logic [FLAG_W-1:0] fl);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_AN_LSB +: AN_W]     = an;
    d[IN_X_LSB +: POS_W]     = x;
    d[IN_Y_LSB +: POS_W]     = y;
    d[IN_Z_LSB +: POS_W]     = z;
    d[IN_FLAG_LSB +: FLAG_W] = fl;
    return d;
  endfunction

  // scan the store in slot order, first slot strictly inside the tolerance wins
  function automatic verdict_t place_atom(input logic [IN_TDATA_W-1:0] d);
    verdict_t                v;
    logic signed [POS_W-1:0] p [3];
    longint                  diff;
    logic [63:0]             mag;
    logic [64:0]             acc;
    bit                      hit;
    v = '0;
    v.status = STATUS_ACCEPTED;
    hit = 1'b0;
    p[0] = d[IN_X_LSB +: POS_W];
    p[1] = d[IN_Y_LSB +: POS_W];
    p[2] = d[IN_Z_LSB +: POS_W];
    if (n_held >= STORE_DEPTH) begin
      v.status = STATUS_FULL;
    end else begin
      for (int i = 0; i < n_held && !hit; i++) begin
        acc = '0;
        for (int a = 0; a < 3; a++) begin
          diff = longint'(p[a]) - longint'(pos_mem[i][a]);
          mag  = (diff < 0) ? -diff : diff;
          // a 32-bit difference never exceeds 2^32-1, so only the sum can saturate
          acc = acc + mag * mag;
          if (acc[64]) begin
            acc = {1'b0, {64{1'b1}}};
          end
        end
        if (acc[63:0] < {24'b0, tol_sq}) begin
          hit = 1'b1;
          v.clash = 8'(i);
        end
      end
      if (hit) begin
        v.status = STATUS_COLOC;
      end else begin
        for (int a = 0; a < 3; a++) begin
          pos_mem[n_held][a] = p[a];
        end
        v.id = serial;
        serial = serial + 1;
        n_held++;
      end
    end
    v.held = 9'(n_held);
    return v;
  endfunction

  // mostly atoms near stored ones, so both clashes and near misses show up
  function automatic logic [IN_TDATA_W-1:0] make_atom();
    int unsigned             r;
    int unsigned             k;
    int                      sb;
    int                      span;
    int                      tlen;
    logic signed [POS_W-1:0] p [3];
    r = $urandom_range(0, 99);
    k = (n_held > 0) ? $urandom_range(0, n_held - 1) : 0;
    tlen = 0;
    for (int b = 0; b < TOL_W; b++) begin
      if (tol_sq[b]) tlen = b + 1;
    end
    sb = tlen / 2 + int'($urandom_range(0, 2)) - 1;
    if (sb < 0) sb = 0;
    span = 1 << sb;
    for (int a = 0; a < 3; a++) begin
      if (r < 8 || n_held == 0) begin
        p[a] = $urandom;
      end else if (r < 20) begin
        p[a] = int'($urandom_range(0, 8191)) - 4096;
      end else if (r < 35) begin
        p[a] = pos_mem[k][a];
      end else begin
        p[a] = pos_mem[k][a] + (int'($urandom_range(0, span)) - (span >>> 1));
      end
    end
    return pack_atom(8'($urandom_range(0, 255)), p[0], p[1], p[2], $urandom);
  endfunction

  task automatic add_row(input logic [AN_W-1:0] an, input logic [POS_W-1:0] x,
                         input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                         input logic [FLAG_W-1:0] fl, input logic typed,
                         input status_e st, input int unsigned id,
                         input int unsigned clash, input int unsigned held);
    dir_row_t row;
    row.data         = pack_atom(an, x, y, z, fl);
    row.typed        = typed;
    row.want.status  = st;
    row.want.id      = id;
    row.want.clash   = 8'(clash);
    row.want.held    = 9'(held);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // enter and leave at a falling edge; tvalid stays high for a back-to-back transfer
  task automatic send_atom(input logic [IN_TDATA_W-1:0] d, input logic typed,
                           input verdict_t typed_v);
    verdict_t v;
    while ($urandom_range(0, 99) < send_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    v = place_atom(d);
    pending_verdicts.insert(pending_verdicts.size(), typed ? typed_v : v);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic set_tolerance(input logic [TOL_W-1:0] value);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tol_sq = value;
    n_tol_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : recv_side
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t           want;
    logic [STAT_W-1:0]  got_status;
    logic [ID_W-1:0]    got_id;
    logic [CLASH_W-1:0] got_clash;
    logic [HELD_W-1:0]  got_held;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_status = m_axis_tdata[OUT_STAT_LSB +: STAT_W];
      got_id     = m_axis_tdata[OUT_ID_LSB +: ID_W];
      got_clash  = m_axis_tdata[OUT_CLASH_LSB +: CLASH_W];
      got_held   = m_axis_tdata[OUT_HELD_LSB +: HELD_W];
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result transfer with nothing outstanding, tdata %h", $time,
                 m_axis_tdata);
        n_errors++;
      end else begin
        want = pending_verdicts.pop_front();
        case (want.status)
          STATUS_ACCEPTED: n_accepted++;
          STATUS_COLOC:    n_coloc++;
          default:         n_full++;
        endcase
        if (got_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
          n_errors++;
        end
        if (got_id !== want.id) begin
          $display("%0t: assigned_id expected %0d actual %0d", $time, want.id, got_id);
          n_errors++;
        end
        if (got_clash !== want.clash) begin
          $display("%0t: clash_index expected %0d actual %0d", $time, want.clash,
                   got_clash);
          n_errors++;
        end
        if (got_held !== want.held) begin
          $display("%0t: atoms_held expected %0d actual %0d", $time, want.held, got_held);
          n_errors++;
        end
      end
    end
  end

  initial begin
    logic [TOL_W-1:0] tol_next;
    int unsigned      n_items;
    verdict_t         no_verdict;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_pct      = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    cycle_count   = 0;
    n_errors      = 0;
    n_sent        = 0;
    n_accepted    = 0;
    n_coloc       = 0;
    n_full        = 0;
    n_tol_writes  = 0;
    n_held        = 0;
    serial        = '0;
    tol_sq        = TOL_RESET;
    no_verdict    = '0;

    // directed rows run at the reset tolerance of 281
    add_row(8'd0, 32'd0, 32'd0, 32'd0, 32'h0000_0000, 1, STATUS_ACCEPTED, 0, 0, 1);
    add_row(8'd255, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1, STATUS_COLOC, 0, 0, 1);
    add_row(8'd1, 32'd16, 32'd4, 32'd0, 32'h0000_0001, 1, STATUS_COLOC, 0, 0, 1);
    // squared distance equal to the tolerance is not a clash
    add_row(8'd2, 32'd16, 32'd5, 32'd0, 32'h8000_0000, 1, STATUS_ACCEPTED, 1, 0, 2);
    add_row(8'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h5555_5555, 1,
            STATUS_ACCEPTED, 2, 0, 3);
    // opposite corners: the distance sum saturates
    add_row(8'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 1,
            STATUS_ACCEPTED, 3, 0, 4);
    add_row(8'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h0F0F_0F0F, 1,
            STATUS_COLOC, 0, 3, 4);
    add_row(8'd6, 32'h8000_0000, 32'h8000_0000, 32'h8000_0010, 32'hF0F0_F0F0, 1,
            STATUS_COLOC, 0, 2, 4);
    add_row(8'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h1234_5678, 0,
            STATUS_ACCEPTED, 0, 0, 0);
    add_row(8'd8, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h8765_4321, 0,
            STATUS_ACCEPTED, 0, 0, 0);
    add_row(8'h80, 32'h0000_0100, 32'hFFFF_FF00, 32'd0, 32'h0000_FFFF, 0,
            STATUS_ACCEPTED, 0, 0, 0);
    add_row(8'h7F, 32'd17, 32'd4, 32'd0, 32'hFFFF_0000, 0, STATUS_ACCEPTED, 0, 0, 0);
    add_row(8'h55, 32'd8, 32'd2, 32'd0, 32'hDEAD_BEEF, 0, STATUS_ACCEPTED, 0, 0, 0);
    add_row(8'hAA, 32'hFFFF_FFF0, 32'd0, 32'hFFFF_FFFF, 32'h0000_0000, 0,
            STATUS_ACCEPTED, 0, 0, 0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_atom(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
    end
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin tol_next = '0;      n_items = 40;  send_pct = 0;  stall_pct = 0;  end
        1: begin tol_next = TOL_MAX; n_items = 250; send_pct = 67; stall_pct = 0;  end
        2: begin tol_next = TOL_RESET; n_items = 300; send_pct = 0; stall_pct = 67; end
        3: begin
          tol_next = 40'($urandom_range(0, 24'hFF_FFFF));
          n_items = 300; send_pct = 35; stall_pct = 35;
        end
        4: begin
          tol_next = {8'($urandom_range(0, 255)), 32'($urandom)};
          n_items = 300; send_pct = 0; stall_pct = 0;
        end
        default: begin
          tol_next = 40'($urandom_range(1, 4096));
          n_items = 650; send_pct = 35; stall_pct = 35;
        end
      endcase
      set_tolerance(tol_next);
      // long receiver hold-off while atoms keep coming, so the input side backs up
      if (ph == 2) hold_req = 1'b1;
      repeat (n_items) send_atom(make_atom(), 1'b0, no_verdict);
      s_axis_tvalid <= 1'b0;
    end

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d atoms over %0d tolerance settings, store ended with %0d atoms",
             n_sent, n_tol_writes, n_held);
    $display("checked results: %0d accepted, %0d colocated, %0d store full",
             n_accepted, n_coloc, n_full);
    if (n_errors == 0) begin
      $display("** point_insert_with_colocation_check: PASSED **");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("** point_insert_with_colocation_check: FAILED **");
    end
    $finish;
  end

endmodule
